// File: hdl/lpht_pkg.sv
package lpht_pkg;

  // Fixed field widths
  localparam int unsigned SIZE_W     = 7;
  localparam int unsigned KEY_W      = 32;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned SLOT_OUT_W = 6;

  localparam int unsigned       MAX_SLOTS_DEF = 64;
  localparam logic [SIZE_W-1:0] SIZE_RESET    = 7'd40;

  // One more than the largest value the 7-bit size register can hold
  localparam int unsigned SIZE_REACH = 128;

  // Remainder unit: key bits retired per cycle
  localparam int unsigned MOD_BITS  = 4;
  localparam int unsigned MOD_STEPS = KEY_W / MOD_BITS;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_SEARCH = 1'b1
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_FOUND     = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_HASH,
    S_PROBE,
    S_RESP
  } state_e;

  typedef struct packed {
    logic              start;
    logic [KEY_W-1:0]  dividend;
    logic [SIZE_W-1:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic              done;
    logic [SIZE_W-1:0] rem;
  } mod_rsp_t;

endpackage

// File: hdl/lpht_req_if.sv
interface lpht_req_if;
  logic                       valid;
  logic                       ready;
  logic                       opcode;
  logic [lpht_pkg::KEY_W-1:0] key;

  modport source (output valid, output opcode, output key, input ready);
  modport sink   (input valid, input opcode, input key, output ready);
endinterface

// File: hdl/lpht_rsp_if.sv
interface lpht_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [lpht_pkg::STATUS_W-1:0]   status;
  logic [lpht_pkg::SLOT_OUT_W-1:0] slot;

  modport source (output valid, output status, output slot, input ready);
  modport sink   (input valid, input status, input slot, output ready);
endinterface

// File: hdl/linear_probe_hash_table.sv
// Open-addressing hash table with linear probing. Each request inserts or
// searches a 32-bit key; the home slot is key mod table_size (0 counts as 1,
// anything above MAX_SLOTS as MAX_SLOTS) and probing walks one slot at a time,
// wrapping at table_size. Insert returns duplicate only when the home slot
// already holds the key, else stores it in the first empty slot, else full.
// Search returns the first occupied slot holding the key, else not found.
// One request is in flight at a time: req.ready is high only while idle, but
// a finished response waits in its own register so the next request can be
// taken meanwhile. The home remainder comes from a restoring unit retiring 4
// key bits a cycle (one load, then eight steps); then one key-store read per
// probed slot is issued, pipelined one a cycle, after which the last slot is
// compared, the end flagged, the response register loaded once it is free,
// and the block returns to idle.
// Occupancy flags clear at reset, so no clearing pass is needed; keys of empty
// slots may be read before written, but the compare ignores them.
// table_size (reset 40) may only be rewritten while the block is idle, and
// rewriting it does not clear stored keys.
module linear_probe_hash_table #(
  parameter int unsigned MAX_SLOTS = lpht_pkg::MAX_SLOTS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  lpht_req_if.sink                    req,
  lpht_rsp_if.source                  rsp,
  input  logic                        cfg_we_i,
  input  logic [lpht_pkg::SIZE_W-1:0] cfg_data_i
);

  // Slots ever reachable: bounded by the 7-bit size register
  localparam int unsigned DEPTH  = (MAX_SLOTS < lpht_pkg::SIZE_REACH) ? MAX_SLOTS
                                                                        : lpht_pkg::SIZE_REACH;
  localparam int unsigned SLOT_W = $clog2(DEPTH);

  logic [lpht_pkg::SIZE_W-1:0] size_q;
  logic [lpht_pkg::SIZE_W-1:0] eff_size;

  lpht_pkg::mod_req_t mod_req;
  lpht_pkg::mod_rsp_t mod_rsp;

  logic                       ram_we, ram_re;
  logic [SLOT_W-1:0]          ram_waddr, ram_raddr;
  logic [lpht_pkg::KEY_W-1:0] ram_wdata, ram_rdata;

  // table size register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= lpht_pkg::SIZE_RESET;
    end else if (cfg_we_i) begin
      size_q <= cfg_data_i;
    end
  end

  // clamp to 1..MAX_SLOTS
  always_comb begin
    if (size_q == '0) begin
      eff_size = lpht_pkg::SIZE_W'(1);
    end else if (32'(size_q) > MAX_SLOTS) begin
      eff_size = lpht_pkg::SIZE_W'(MAX_SLOTS);
    end else begin
      eff_size = size_q;
    end
  end

  lpht_mod u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mod_req),
    .rsp_o  (mod_rsp)
  );

  // key store, one write and one registered read port
  lpht_ram #(
    .WIDTH (lpht_pkg::KEY_W),
    .DEPTH (DEPTH)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  lpht_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req         (req),
    .rsp         (rsp),
    .eff_size_i  (eff_size),
    .mod_req_o   (mod_req),
    .mod_rsp_i   (mod_rsp),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

endmodule

// File: hdl/lpht_ram.sv
module lpht_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// File: hdl/lpht_mod.sv
// Key modulo table size, restoring, MOD_BITS key bits per cycle.
module lpht_mod (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lpht_pkg::mod_req_t req_i,
  output lpht_pkg::mod_rsp_t rsp_o
);

  localparam int unsigned CNT_W = $clog2(lpht_pkg::MOD_STEPS);

  logic                           busy_q, busy_d;
  logic                           done_q, done_d;
  logic [CNT_W-1:0]               cnt_q, cnt_d;
  logic [lpht_pkg::KEY_W-1:0]     acc_q, acc_d;
  logic [lpht_pkg::SIZE_W-1:0]    div_q, div_d;
  logic [lpht_pkg::SIZE_W-1:0]    rem_q, rem_d;
  logic [lpht_pkg::SIZE_W-1:0]    step_rem;

  // MOD_BITS dependent shift-compare-subtract steps on a narrow remainder
  always_comb begin : step
    logic [lpht_pkg::SIZE_W:0] t;
    step_rem = rem_q;
    for (int i = 0; i < lpht_pkg::MOD_BITS; i++) begin
      t = {step_rem, acc_q[lpht_pkg::KEY_W-1-i]};
      if (t >= {1'b0, div_q}) begin
        t = t - {1'b0, div_q};
      end
      step_rem = t[lpht_pkg::SIZE_W-1:0];
    end
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    div_d  = div_q;
    rem_d  = rem_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      acc_d  = req_i.dividend;
      div_d  = req_i.divisor;
      rem_d  = '0;
    end else if (busy_q) begin
      rem_d = step_rem;
      acc_d = acc_q << lpht_pkg::MOD_BITS;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(lpht_pkg::MOD_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    div_q <= div_d;
    rem_q <= rem_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;

endmodule

// File: hdl/lpht_ctrl.sv
// Request sequencer: hash, pipelined probe walk, response register.
module lpht_ctrl #(
  parameter int unsigned DEPTH = lpht_pkg::MAX_SLOTS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  lpht_req_if.sink                    req,
  lpht_rsp_if.source                  rsp,
  input  logic [lpht_pkg::SIZE_W-1:0] eff_size_i,
  output lpht_pkg::mod_req_t          mod_req_o,
  input  lpht_pkg::mod_rsp_t          mod_rsp_i,
  output logic                        ram_we_o,
  output logic [$clog2(DEPTH)-1:0]    ram_waddr_o,
  output logic [lpht_pkg::KEY_W-1:0]  ram_wdata_o,
  output logic                        ram_re_o,
  output logic [$clog2(DEPTH)-1:0]    ram_raddr_o,
  input  logic [lpht_pkg::KEY_W-1:0]  ram_rdata_i
);

  localparam int unsigned SLOT_W = $clog2(DEPTH);
  localparam int unsigned SW     = lpht_pkg::SIZE_W;

  lpht_pkg::state_e  state_q, state_d;
  lpht_pkg::op_e     op_q, op_d;
  lpht_pkg::status_e res_status_q, res_status_d;
  lpht_pkg::status_e rsp_status_q, rsp_status_d;

  logic [lpht_pkg::KEY_W-1:0]     key_q, key_d;
  logic [SW-1:0]                  n_q, n_d;
  logic [SW-1:0]                  iss_loc_q, iss_loc_d;
  logic [SW-1:0]                  iss_cnt_q, iss_cnt_d;
  logic                           cmp_vld_q, cmp_vld_d;
  logic [SW-1:0]                  cmp_loc_q, cmp_loc_d;
  logic                           cmp_first_q, cmp_first_d;
  logic [DEPTH-1:0]               occ_q, occ_d;
  logic [SW-1:0]                  res_slot_q, res_slot_d;
  logic                           rsp_vld_q, rsp_vld_d;
  logic [lpht_pkg::SLOT_OUT_W-1:0] rsp_slot_q, rsp_slot_d;

  logic cmp_occ, cmp_hit, issue_en, exhausted, ins_stop, srch_stop, rsp_free;

  always_comb begin
    cmp_occ   = occ_q[SLOT_W'(cmp_loc_q)];
    cmp_hit   = cmp_occ && (ram_rdata_i == key_q);
    issue_en  = (state_q == lpht_pkg::S_PROBE) && (iss_cnt_q != n_q);
    exhausted = (state_q == lpht_pkg::S_PROBE) && !cmp_vld_q && (iss_cnt_q == n_q);
    ins_stop  = (state_q == lpht_pkg::S_PROBE) && cmp_vld_q && (op_q == lpht_pkg::OP_INSERT)
                && ((cmp_first_q && cmp_hit) || !cmp_occ);
    srch_stop = (state_q == lpht_pkg::S_PROBE) && cmp_vld_q && (op_q == lpht_pkg::OP_SEARCH)
                && cmp_hit;
    rsp_free  = !rsp_vld_q || rsp.ready;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      lpht_pkg::S_IDLE: begin
        if (req.valid) begin
          state_d = lpht_pkg::S_HASH;
        end
      end
      lpht_pkg::S_HASH: begin
        if (mod_rsp_i.done) begin
          state_d = lpht_pkg::S_PROBE;
        end
      end
      lpht_pkg::S_PROBE: begin
        if (ins_stop || srch_stop || exhausted) begin
          state_d = lpht_pkg::S_RESP;
        end
      end
      lpht_pkg::S_RESP: begin
        if (rsp_free) begin
          state_d = lpht_pkg::S_IDLE;
        end
      end
      default: state_d = lpht_pkg::S_IDLE;
    endcase
  end

  // Datapath control
  always_comb begin
    op_d         = op_q;
    key_d        = key_q;
    n_d          = n_q;
    iss_loc_d    = iss_loc_q;
    iss_cnt_d    = iss_cnt_q;
    cmp_vld_d    = cmp_vld_q;
    cmp_loc_d    = cmp_loc_q;
    cmp_first_d  = cmp_first_q;
    occ_d        = occ_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    rsp_vld_d    = rsp_vld_q && !rsp.ready;
    rsp_status_d = rsp_status_q;
    rsp_slot_d   = rsp_slot_q;

    mod_req_o.start    = 1'b0;
    mod_req_o.dividend = req.key;
    mod_req_o.divisor  = eff_size_i;

    ram_we_o    = 1'b0;
    ram_waddr_o = SLOT_W'(cmp_loc_q);
    ram_wdata_o = key_q;
    ram_re_o    = 1'b0;
    ram_raddr_o = SLOT_W'(iss_loc_q);

    case (state_q)
      lpht_pkg::S_IDLE: begin
        if (req.valid) begin
          op_d            = lpht_pkg::op_e'(req.opcode);
          key_d           = req.key;
          n_d             = eff_size_i;
          mod_req_o.start = 1'b1;
        end
      end
      lpht_pkg::S_HASH: begin
        iss_loc_d = mod_rsp_i.rem;
        iss_cnt_d = '0;
        cmp_vld_d = 1'b0;
      end
      lpht_pkg::S_PROBE: begin
        // issue read of the next slot while comparing the previous one
        cmp_vld_d = issue_en;
        if (issue_en) begin
          ram_re_o    = 1'b1;
          cmp_loc_d   = iss_loc_q;
          cmp_first_d = (iss_cnt_q == '0);
          iss_cnt_d   = iss_cnt_q + 1'b1;
          iss_loc_d   = (iss_loc_q + 1'b1 == n_q) ? '0 : iss_loc_q + 1'b1;
        end
        if (ins_stop) begin
          res_slot_d = cmp_loc_q;
          if (cmp_first_q && cmp_hit) begin
            res_status_d = lpht_pkg::ST_DUPLICATE;
          end else begin
            res_status_d                = lpht_pkg::ST_INSERTED;
            ram_we_o                    = 1'b1;
            occ_d[SLOT_W'(cmp_loc_q)]   = 1'b1;
          end
        end else if (srch_stop) begin
          res_status_d = lpht_pkg::ST_FOUND;
          res_slot_d   = cmp_loc_q;
        end else if (exhausted) begin
          res_status_d = (op_q == lpht_pkg::OP_INSERT) ? lpht_pkg::ST_FULL
                                                       : lpht_pkg::ST_NOT_FOUND;
          res_slot_d   = '0;
        end
      end
      lpht_pkg::S_RESP: begin
        if (rsp_free) begin
          rsp_vld_d    = 1'b1;
          rsp_status_d = res_status_q;
          rsp_slot_d   = lpht_pkg::SLOT_OUT_W'(res_slot_q);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= lpht_pkg::S_IDLE;
      occ_q     <= '0;
      rsp_vld_q <= 1'b0;
      cmp_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      occ_q     <= occ_d;
      rsp_vld_q <= rsp_vld_d;
      cmp_vld_q <= cmp_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    key_q        <= key_d;
    n_q          <= n_d;
    iss_loc_q    <= iss_loc_d;
    iss_cnt_q    <= iss_cnt_d;
    cmp_loc_q    <= cmp_loc_d;
    cmp_first_q  <= cmp_first_d;
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    rsp_status_q <= rsp_status_d;
    rsp_slot_q   <= rsp_slot_d;
  end

  assign req.ready  = (state_q == lpht_pkg::S_IDLE);
  assign rsp.valid  = rsp_vld_q;
  assign rsp.status = rsp_status_q;
  assign rsp.slot   = rsp_slot_q;

endmodule
